// File: design/command_line_splitter_assert.svh
// assertion macros for the command line splitter
`ifndef COMMAND_LINE_SPLITTER_ASSERT_SVH
`define COMMAND_LINE_SPLITTER_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define CLS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("command_line_splitter: assertion failed");
// checked on every edge, reset included
`define CLS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("command_line_splitter: assertion failed");
`else
`define CLS_ASSERT(lbl, prop)
`define CLS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: design/cls_pkg.sv
`timescale 1ns / 1ps

package cls_pkg;

    localparam int RUN_BITS_DEF   = 10;
    localparam int COUNT_BITS_DEF = 16;

    // fixed widths of the result fields
    localparam int RUN_OUT_W  = 10;
    localparam int ARG_OUT_W  = 16;
    localparam int CHAR_OUT_W = 17;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_RUN  = 2'd2,
        KIND_SUM  = 2'd3
    } t_kind;

    // second piece of a queued command
    typedef enum logic [1:0] {
        SEC_NONE,
        SEC_BYTE,
        SEC_END
    } t_sec;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             data_byte;
        logic [RUN_OUT_W-1:0]   run_length;
        logic                   run_saturated;
        logic [ARG_OUT_W-1:0]   arg_total;
        logic [CHAR_OUT_W-1:0]  char_total;
        logic                   final_of_run;
    } t_res;

    // up to three results of one input transaction: run, byte or end, summary
    typedef struct packed {
        logic                   has_run;
        logic [RUN_OUT_W-1:0]   run_len;
        logic                   run_sat;
        t_sec                   sec;
        logic [7:0]             sec_byte;
        logic                   has_sum;
        logic [ARG_OUT_W-1:0]   arg_total;
        logic [CHAR_OUT_W-1:0]  char_total;
    } t_cmd;

endpackage

// File: design/command_line_splitter.sv
// a result passes from the front through the command queue and then the registered output stage to o_result
// throughput: one input byte per cycle while each byte gives at most one result and i_stall is low;
// a byte that gives several results (up to 3) holds the result side until all of them are out
// a four-entry command queue lets the input side run ahead of the result side
// reset: i_rst_n low at a rising edge clears the parser state, totals, queue and o_valid
`timescale 1ns / 1ps
`include "command_line_splitter_assert.svh"

module command_line_splitter import cls_pkg::*; #(
    parameter int RUN_BITS   = RUN_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input channel
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_item,
    // result channel
    output logic o_valid,
    input  logic i_stall,
    output t_res o_result
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic in_accept;
    t_cmd front_cmd;
    t_cmd q_head;

    // input side stalls only when the command queue has no free entry
    assign o_stall   = q_full;
    assign in_accept = i_valid && !q_full;

    // front: classifies each byte, keeps quoting, backslash run and totals,
    // and turns the transaction into one command of up to three results
    cls_front #(
        .RUN_BITS   (RUN_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_item),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    // short queue between the two sides, bytes that give no result skip it
    cls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: expands the head command into results, one per cycle while i_stall is low,
    // through a registered output stage
    cls_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    // a command is never written into a full queue
    `CLS_ASSERT(a_no_push_full, q_push |-> !q_full)
    // the line summary always closes the results of its transaction
    `CLS_ASSERT(a_sum_final, (o_valid && o_result.kind == KIND_SUM) |-> o_result.final_of_run)
    // with nothing queued and nothing shown, no result can appear
    `CLS_ASSERT(a_idle_quiet, (q_empty && !o_valid) |=> !o_valid)
    // reset empties the result stage
    `CLS_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_valid)

endmodule

// File: design/cls_front.sv
`timescale 1ns / 1ps

module cls_front import cls_pkg::*; #(
    parameter int RUN_BITS   = RUN_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_item,
    output logic o_push,
    output t_cmd o_cmd
);

    localparam int BYTE_BITS = COUNT_BITS + 1;
    localparam int SUM_W     = ((BYTE_BITS > RUN_BITS) ? BYTE_BITS : RUN_BITS) + 1;
    localparam logic [RUN_BITS-1:0]   RUN_MAX  = {RUN_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] ARG_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [BYTE_BITS-1:0]  BYTE_MAX = {BYTE_BITS{1'b1}};

    logic                  r_quoting, n_quoting;
    logic                  r_inside, n_inside;
    logic                  r_pending, n_pending;
    logic [RUN_BITS-1:0]   r_run, n_run;
    logic                  r_ovf, n_ovf;
    logic [COUNT_BITS-1:0] r_argc, n_argc;
    logic [BYTE_BITS-1:0]  r_bytes, n_bytes;

    logic [7:0]            b;
    logic                  eot;
    logic                  is_ws;
    logic                  do_inside;
    logic                  q_eff;
    logic [RUN_BITS-1:0]   len;
    logic                  has_run;
    t_sec                  sec;
    logic [7:0]            sec_byte;
    logic [SUM_W-1:0]      bytes_sum;
    logic [BYTE_BITS-1:0]  bytes_sat;
    logic [COUNT_BITS-1:0] arg_next;

    assign b     = i_item.text_byte;
    assign eot   = i_item.end_of_text;
    assign is_ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);

    always_comb begin
        n_quoting = r_quoting;
        n_inside  = r_inside;
        n_pending = r_pending;
        n_run     = r_run;
        n_ovf     = r_ovf;
        n_argc    = r_argc;
        len       = '0;
        has_run   = 1'b0;
        sec       = SEC_NONE;
        sec_byte  = '0;
        do_inside = 1'b0;
        q_eff     = r_quoting;
        if (eot) begin
            if (r_inside) begin
                len     = r_run;
                has_run = (r_run != '0);
                sec     = SEC_END;
            end
            n_quoting = 1'b0;
            n_inside  = 1'b0;
            n_pending = 1'b0;
            n_run     = '0;
            n_ovf     = 1'b0;
            n_argc    = '0;
        end else if (r_pending) begin
            n_pending = 1'b0;
            if (b == CH_QUOTE) begin
                sec      = SEC_BYTE;
                sec_byte = CH_QUOTE;
            end else begin
                n_quoting = 1'b0;
                q_eff     = 1'b0;
                do_inside = 1'b1;
            end
        end else if (!r_inside) begin
            if (!is_ws) begin
                if (r_argc != ARG_MAX) begin
                    n_argc = r_argc + 1'b1;
                end
                n_inside  = 1'b1;
                do_inside = 1'b1;
            end
        end else begin
            do_inside = 1'b1;
        end

        if (do_inside) begin
            if (b == CH_BSLASH) begin
                if (r_run == RUN_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    n_run = r_run + 1'b1;
                end
            end else if (b == CH_QUOTE) begin
                len     = r_run >> 1;
                has_run = ((r_run >> 1) != '0);
                n_run   = '0;
                n_ovf   = 1'b0;
                if (!r_run[0]) begin
                    if (q_eff) begin
                        n_pending = 1'b1;
                    end else begin
                        n_quoting = 1'b1;
                    end
                end else begin
                    sec      = SEC_BYTE;
                    sec_byte = CH_QUOTE;
                end
            end else begin
                len     = r_run;
                has_run = (r_run != '0);
                n_run   = '0;
                n_ovf   = 1'b0;
                if (b == CH_NL || (!q_eff && (b == CH_SPACE || b == CH_TAB))) begin
                    sec      = SEC_END;
                    n_inside = 1'b0;
                end else begin
                    sec      = SEC_BYTE;
                    sec_byte = b;
                end
            end
        end
    end

    // saturating byte total, run and byte or end added together
    assign bytes_sum = SUM_W'(r_bytes) + SUM_W'(len) + SUM_W'(sec != SEC_NONE);
    assign bytes_sat = (bytes_sum > SUM_W'(BYTE_MAX)) ? BYTE_MAX : BYTE_BITS'(bytes_sum);
    assign n_bytes   = eot ? '0 : bytes_sat;
    assign arg_next  = (r_argc == ARG_MAX) ? r_argc : r_argc + 1'b1;

    always_comb begin
        o_cmd.has_run    = has_run;
        o_cmd.run_len    = RUN_OUT_W'(len);
        o_cmd.run_sat    = r_ovf;
        o_cmd.sec        = sec;
        o_cmd.sec_byte   = sec_byte;
        o_cmd.has_sum    = eot;
        o_cmd.arg_total  = ARG_OUT_W'(arg_next);
        o_cmd.char_total = CHAR_OUT_W'(bytes_sat);
    end

    assign o_push = i_accept && (has_run || (sec != SEC_NONE) || eot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoting <= 1'b0;
            r_inside  <= 1'b0;
            r_pending <= 1'b0;
            r_run     <= '0;
            r_ovf     <= 1'b0;
            r_argc    <= '0;
            r_bytes   <= '0;
        end else if (i_accept) begin
            r_quoting <= n_quoting;
            r_inside  <= n_inside;
            r_pending <= n_pending;
            r_run     <= n_run;
            r_ovf     <= n_ovf;
            r_argc    <= n_argc;
            r_bytes   <= n_bytes;
        end
    end

endmodule

// File: design/cls_queue.sv
`timescale 1ns / 1ps

module cls_queue import cls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// File: design/cls_back.sv
`timescale 1ns / 1ps

module cls_back import cls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_head,
    input  logic i_empty,
    output logic o_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_result
);

    logic [2:0] r_done, n_done;
    logic       r_valid;
    t_res       r_res, n_res;
    logic [2:0] pieces;
    logic [2:0] remain;
    logic [2:0] pick;
    logic       last;
    logic       can_load;

    assign can_load = !r_valid || !i_stall;
    assign pieces   = {i_head.has_sum, i_head.sec != SEC_NONE, i_head.has_run};
    assign remain   = pieces & ~r_done;
    assign pick     = remain[0] ? 3'b001 : (remain[1] ? 3'b010 : 3'b100);
    assign last     = ((remain & ~pick) == 3'b000);
    assign o_pop    = can_load && !i_empty && last;

    always_comb begin
        n_done = r_done;
        if (can_load && !i_empty) begin
            n_done = last ? 3'b000 : (r_done | pick);
        end
    end

    always_comb begin
        n_res               = '0;
        n_res.final_of_run  = last;
        if (pick[0]) begin
            n_res.kind          = KIND_RUN;
            n_res.data_byte     = CH_BSLASH;
            n_res.run_length    = i_head.run_len;
            n_res.run_saturated = i_head.run_sat;
        end else if (pick[1]) begin
            if (i_head.sec == SEC_END) begin
                n_res.kind = KIND_END;
            end else begin
                n_res.kind      = KIND_BYTE;
                n_res.data_byte = i_head.sec_byte;
            end
        end else begin
            n_res.kind       = KIND_SUM;
            n_res.arg_total  = i_head.arg_total;
            n_res.char_total = i_head.char_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 3'b000;
        end else begin
            r_done <= n_done;
            if (can_load) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && !i_empty) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cls_pkg::*;

    // limits of the saturating counters at the default widths
    localparam int RUN_TOP      = (1 << RUN_BITS_DEF) - 1;
    localparam int ARG_TOP      = (1 << COUNT_BITS_DEF) - 1;
    localparam int CHAR_TOP     = (1 << (COUNT_BITS_DEF + 1)) - 1;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 40;
    localparam int HOLD_AT      = 120;
    localparam int RANDOM_ITEMS = 430;
    localparam int SETTLE       = 20;

    // one input transaction waiting to be offered
    typedef struct {
        t_in         item;
        int unsigned gap;
        bit          drain;
    } t_pending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_item  = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_res o_result;

    command_line_splitter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pending pend[$];
    t_res     want_results[$];
    t_res     burst[$];

    bit tx_calm = 1'b0;
    int errors = 0;
    int items_taken = 0;
    int res_count = 0;
    int lines_closed = 0;
    int runs_seen = 0;
    int peak_args = 0;

    logic item_taken = 1'b0;
    logic res_taken  = 1'b0;

    // ------------------------------------------------------------------
    // splitter state as the tokeniser sees it
    // ------------------------------------------------------------------
    bit in_quotes;
    bit in_arg;
    bit quote_held;     // closing quote seen inside quotes, next byte decides
    bit bs_sat;
    int bs_run;
    int arg_cnt;
    int chr_cnt;

    function automatic void clear_parser();
        in_quotes  = 1'b0;
        in_arg     = 1'b0;
        quote_held = 1'b0;
        bs_sat     = 1'b0;
        bs_run     = 0;
        arg_cnt    = 0;
        chr_cnt    = 0;
    endfunction

    function automatic void add_chars(int n);
        chr_cnt = (CHAR_TOP - chr_cnt < n) ? CHAR_TOP : chr_cnt + n;
    endfunction

    function automatic void push_res(t_kind k, logic [7:0] d, int run, bit sat, int at, int ct);
        t_res r;
        r = '0;
        r.kind          = k;
        r.data_byte     = d;
        r.run_length    = RUN_OUT_W'(run);
        r.run_saturated = sat;
        r.arg_total     = ARG_OUT_W'(at);
        r.char_total    = CHAR_OUT_W'(ct);
        burst.push_back(r);
    endfunction

    // backslashes released as one run; the run counter starts afresh
    function automatic void flush_run(int len);
        if (len > 0) begin
            push_res(KIND_RUN, CH_BSLASH, len, bs_sat, 0, 0);
            add_chars(len);
        end
        bs_run = 0;
        bs_sat = 1'b0;
    endfunction

    function automatic void put_char(logic [7:0] b);
        push_res(KIND_BYTE, b, 0, 1'b0, 0, 0);
        add_chars(1);
    endfunction

    function automatic void close_arg();
        push_res(KIND_END, 8'd0, 0, 1'b0, 0, 0);
        add_chars(1);
        in_arg = 1'b0;
    endfunction

    // one byte inside an open argument
    function automatic void arg_char(logic [7:0] b);
        bit even;
        if (b == CH_BSLASH) begin
            if (bs_run >= RUN_TOP) begin
                bs_run = RUN_TOP;
                bs_sat = 1'b1;
            end else begin
                bs_run++;
            end
            return;
        end
        if (b == CH_QUOTE) begin
            even = (bs_run % 2) == 0;
            flush_run(bs_run / 2);
            if (!even)
                put_char(CH_QUOTE);
            else if (in_quotes)
                quote_held = 1'b1;
            else
                in_quotes = 1'b1;
            return;
        end
        flush_run(bs_run);
        if (b == CH_NL || (!in_quotes && (b == CH_SPACE || b == CH_TAB)))
            close_arg();
        else
            put_char(b);
    endfunction

    // works out the results of one accepted input transaction
    function automatic void split_char(t_in it);
        logic [7:0] b;
        b = it.text_byte;
        burst.delete();
        if (it.end_of_text) begin
            if (in_arg) begin
                if (quote_held) begin
                    quote_held = 1'b0;
                    in_quotes  = 1'b0;
                end
                flush_run(bs_run);
                close_arg();
            end
            push_res(KIND_SUM, 8'd0, 0, 1'b0,
                     (arg_cnt >= ARG_TOP) ? ARG_TOP : arg_cnt + 1, chr_cnt);
            clear_parser();
        end else if (quote_held) begin
            quote_held = 1'b0;
            if (b == CH_QUOTE) begin
                put_char(CH_QUOTE);
            end else begin
                in_quotes = 1'b0;
                arg_char(b);
            end
        end else if (!in_arg) begin
            if (b != CH_SPACE && b != CH_TAB && b != CH_NL) begin
                if (arg_cnt < ARG_TOP)
                    arg_cnt++;
                in_arg = 1'b1;
                arg_char(b);
            end
        end else begin
            arg_char(b);
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].final_of_run = 1'b1;
        foreach (burst[k])
            want_results.push_back(burst[k]);
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: results are checked first, then the accepted input
    // transaction is predicted, all on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            res_count++;
            if (want_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, o_result);
            end else begin
                want = want_results.pop_front();
                check_field("kind", want.kind, o_result.kind);
                check_field("data_byte", want.data_byte, o_result.data_byte);
                check_field("run_length", want.run_length, o_result.run_length);
                check_field("run_saturated", want.run_saturated, o_result.run_saturated);
                check_field("arg_total", want.arg_total, o_result.arg_total);
                check_field("char_total", want.char_total, o_result.char_total);
                check_field("final_of_run", want.final_of_run, o_result.final_of_run);
                if (want.kind == KIND_SUM) begin
                    lines_closed++;
                    if (want.arg_total > peak_args)
                        peak_args = want.arg_total;
                end
                if (want.kind == KIND_RUN)
                    runs_seen++;
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            items_taken++;
            split_char(i_item);
        end
        item_taken <= i_rst_n && i_valid && !o_stall;
        res_taken  <= i_rst_n && o_valid && !i_stall;
    end

    // ------------------------------------------------------------------
    // driver: offers the pending transactions on the falling edge, each
    // after its own idle gap; a drain mark holds it back until every
    // expected result has come out
    // ------------------------------------------------------------------
    int unsigned tx_idle = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_item  <= '0;
        end else if (!i_valid || item_taken) begin
            if (pend.size() > 0 && tx_idle >= pend[0].gap
                    && !(pend[0].drain && want_results.size() > 0)) begin
                i_item  <= pend[0].item;
                i_valid <= 1'b1;
                void'(pend.pop_front());
                tx_idle = 0;
            end else begin
                i_valid <= 1'b0;
                tx_idle++;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall before each result, calm stretches, and one
    // long hold-off so that the command queue fills and stalls the input
    // ------------------------------------------------------------------
    int unsigned rx_wait = 0;
    int unsigned hold_left = 0;
    bit held_off = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (res_taken)
                rx_wait = ((res_count / 64) % 4 == 3) ? 0 : $urandom_range(0, 3);
            if (!held_off && res_count >= HOLD_AT) begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog: too long without any transaction on either side
    int unsigned quiet = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(logic [7:0] b, bit eol, bit drain);
        t_pending p;
        p.item.text_byte   = b;
        p.item.end_of_text = eol;
        p.gap   = tx_calm ? 0 : $urandom_range(0, 3);
        p.drain = drain;
        pend.push_back(p);
    endtask

    task automatic queue_text(string s);
        for (int k = 0; k < s.len(); k++)
            queue_item(s[k], 1'b0, 1'b0);
    endtask

    initial begin
        int unsigned rnd_items;
        int unsigned line_no;
        int unsigned len;
        logic [7:0] ch;

        clear_parser();

        // doubled quote inside quotes, pending quote then space, odd and
        // even backslash runs before a quote, tab kept while quoting
        queue_text("\"a\"\"b\" \\\"\\\\\"z\t");
        queue_item(8'hFF, 1'b1, 1'b0);
        // quoting carried over a newline, zero byte and top byte as text
        queue_text("\"p\nr s\" ");
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0);
        // pending quote closed by end of text
        queue_text("\"z\"");
        queue_item(CH_QUOTE, 1'b1, 1'b0);
        // empty line
        queue_item(CH_SPACE, 1'b1, 1'b0);
        // leading whitespace skipped, backslash run closed by end of text
        queue_text("\n\t\\\\");
        queue_item(8'h5A, 1'b1, 1'b0);

        // random lines, weighted towards the characters with meaning
        rnd_items = 0;
        line_no   = 0;
        while (rnd_items < RANDOM_ITEMS) begin
            tx_calm = (line_no % 8) >= 6;
            len = $urandom_range(0, 24);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 15))
                    0, 1, 2: ch = CH_BSLASH;
                    3, 4:    ch = CH_QUOTE;
                    5:       ch = CH_SPACE;
                    6:       ch = CH_TAB;
                    7:       ch = CH_NL;
                    8, 9:    ch = $urandom_range(0, 255);
                    default: ch = 8'h61 + $urandom_range(0, 25);
                endcase
                queue_item(ch, 1'b0, 1'b0);
            end
            // on lines 12 and 30 the sender pauses here until the block has drained
            queue_item($urandom_range(0, 255), 1'b1, line_no == 12 || line_no == 30);
            rnd_items += len + 1;
            line_no++;
        end

        // reset held low from the start, released on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend.size() > 0 || i_valid || want_results.size() > 0)
            @(posedge i_clk);
        // catch any stray result after the last one expected
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d input transactions in %0d lines, %0d results checked",
                 items_taken, lines_closed, res_count);
        $display("backslash runs checked: %0d, largest argument total: %0d",
                 runs_seen, peak_args);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
